FILE: hw/rtl/quic_long_header_parser_defines.svh
// Assertion macros shared by the QUIC long header parser RTL.
`ifndef QUIC_LONG_HEADER_PARSER_DEFINES_SVH
`define QUIC_LONG_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication, checked on clk outside of reset.
`define QLHP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qlhp check failed");

// Next-cycle implication, checked on clk outside of reset.
`define QLHP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qlhp check failed");

`endif

FILE: hw/rtl/qlhp_pkg.sv
// Types, constants and codes shared by the QUIC long header parser.
`timescale 1ns / 1ps

package qlhp_pkg;

  // Header limits.
  localparam int MAX_ID_LEN    = 20;
  localparam int MIN_HDR_LEN   = 7;
  localparam int VERSION_BYTES = 4;

  // Internal widths follow from the connection ID limit.
  localparam int LEN_W  = $clog2(MAX_ID_LEN + 1);
  localparam int CNT_W  = (LEN_W > 3) ? LEN_W : 3;
  localparam int HLEN_W = $clog2(MIN_HDR_LEN + 2 * MAX_ID_LEN + 1);

  // Result bus widths.
  localparam int OUT_DATA_W = 80;
  localparam int OUT_USER_W = 2;

  localparam logic [7:0] FORM_BIT  = 8'h80;
  localparam logic [7:0] TYPE_MASK = 8'h03;

  // Parser phases.
  localparam logic [2:0] PH_FIRST   = 3'd0;
  localparam logic [2:0] PH_VERSION = 3'd1;
  localparam logic [2:0] PH_DLEN    = 3'd2;
  localparam logic [2:0] PH_DCID    = 3'd3;
  localparam logic [2:0] PH_SLEN    = 3'd4;
  localparam logic [2:0] PH_SCID    = 3'd5;
  localparam logic [2:0] PH_SKIP    = 3'd6;

  // Result kinds.
  localparam logic [1:0] K_DCID  = 2'd0;
  localparam logic [1:0] K_SCID  = 2'd1;
  localparam logic [1:0] K_DONE  = 2'd2;
  localparam logic [1:0] K_ERROR = 2'd3;

  // Error codes.
  localparam logic [1:0] E_NONE  = 2'd0;
  localparam logic [1:0] E_FORM  = 2'd1;
  localparam logic [1:0] E_IDLEN = 2'd2;
  localparam logic [1:0] E_TRUNC = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  cid_byte;
    logic [4:0]  cid_index;
    logic [7:0]  header_first_byte;
    logic [1:0]  packet_type;
    logic [31:0] version;
    logic [4:0]  dest_id_len;
    logic [4:0]  src_id_len;
    logic [5:0]  header_len;
    logic [1:0]  error_code;
    logic        end_of_item;
  } qlhp_result_t;

  // Results that one byte produces, in order, and how many are real.
  typedef struct packed {
    qlhp_result_t res0;
    qlhp_result_t res1;
    logic [1:0]   count;
  } qlhp_step_t;

endpackage

FILE: hw/rtl/qlhp_core.sv
// Header parsing state and the per-byte step logic of the QUIC long header parser.
`timescale 1ns / 1ps

module qlhp_core
  import qlhp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       item_valid,
  input  logic [7:0] item_byte,
  input  logic       item_last,
  input  logic       step_fire,
  output qlhp_step_t step
);

  logic [2:0]        phase_r, phase_nxt;
  logic [CNT_W-1:0]  fc_r, fc_nxt;
  logic [7:0]        fb_r, fb_nxt;
  logic [31:0]       ver_r, ver_nxt;
  logic [LEN_W-1:0]  dl_r, dl_nxt;
  logic [LEN_W-1:0]  sl_r, sl_nxt;
  logic [HLEN_W-1:0] bc_r, bc_nxt;

  logic [CNT_W-1:0]  fc_inc;
  logic              cid_hit;
  logic [1:0]        cid_kind;
  logic              err_hit;
  logic [1:0]        err_code;
  logic              sum_hit;
  logic              tail_hit;
  logic [7:0]        ptype_wide;
  qlhp_result_t      cid_res;
  qlhp_result_t      tail_res;

  // Next state and result selection for the byte in the input register.
  always_comb begin
    phase_nxt = phase_r;
    fc_nxt    = fc_r;
    fb_nxt    = fb_r;
    ver_nxt   = ver_r;
    dl_nxt    = dl_r;
    sl_nxt    = sl_r;
    bc_nxt    = bc_r;
    cid_hit   = 1'b0;
    cid_kind  = K_DCID;
    err_hit   = 1'b0;
    err_code  = E_NONE;
    sum_hit   = 1'b0;
    fc_inc    = fc_r + 1'b1;

    // Every header byte counts toward the header length.
    if (phase_r <= PH_SCID) begin
      bc_nxt = bc_r + 1'b1;
    end

    case (phase_r)
      PH_FIRST: begin
        fb_nxt  = item_byte;
        bc_nxt  = HLEN_W'(1);
        fc_nxt  = '0;
        ver_nxt = '0;
        dl_nxt  = '0;
        sl_nxt  = '0;
        if ((item_byte & FORM_BIT) == 8'h00) begin
          err_hit  = 1'b1;
          err_code = E_FORM;
        end else if (item_last) begin
          err_hit  = 1'b1;
          err_code = E_TRUNC;
        end else begin
          phase_nxt = PH_VERSION;
        end
      end
      PH_VERSION: begin
        ver_nxt = {ver_r[23:0], item_byte};
        fc_nxt  = fc_inc;
        if (item_last) begin
          err_hit  = 1'b1;
          err_code = E_TRUNC;
        end else if (fc_inc >= CNT_W'(VERSION_BYTES)) begin
          phase_nxt = PH_DLEN;
        end
      end
      PH_DLEN: begin
        dl_nxt = item_byte[LEN_W-1:0];
        if (item_byte > 8'(MAX_ID_LEN)) begin
          err_hit  = 1'b1;
          err_code = E_IDLEN;
        end else if (item_last) begin
          err_hit  = 1'b1;
          err_code = E_TRUNC;
        end else begin
          fc_nxt    = '0;
          phase_nxt = (item_byte == 8'h00) ? PH_SLEN : PH_DCID;
        end
      end
      PH_DCID: begin
        cid_hit  = 1'b1;
        cid_kind = K_DCID;
        fc_nxt   = fc_inc;
        if (item_last) begin
          err_hit  = 1'b1;
          err_code = E_TRUNC;
        end else if (fc_inc >= CNT_W'(dl_r)) begin
          phase_nxt = PH_SLEN;
        end
      end
      PH_SLEN: begin
        sl_nxt = item_byte[LEN_W-1:0];
        if (item_byte > 8'(MAX_ID_LEN)) begin
          err_hit  = 1'b1;
          err_code = E_IDLEN;
        end else if (item_byte == 8'h00) begin
          sum_hit = 1'b1;
        end else if (item_last) begin
          err_hit  = 1'b1;
          err_code = E_TRUNC;
        end else begin
          fc_nxt    = '0;
          phase_nxt = PH_SCID;
        end
      end
      PH_SCID: begin
        cid_hit  = 1'b1;
        cid_kind = K_SCID;
        fc_nxt   = fc_inc;
        if (fc_inc >= CNT_W'(sl_r)) begin
          sum_hit = 1'b1;
        end else if (item_last) begin
          err_hit  = 1'b1;
          err_code = E_TRUNC;
        end
      end
      default: begin
        // Trailing bytes after a summary or an error are dropped.
      end
    endcase

    // The flagged last byte always rearms the parser.
    if (item_last) begin
      phase_nxt = PH_FIRST;
    end else if (err_hit || sum_hit) begin
      phase_nxt = PH_SKIP;
    end
  end

  // Build the connection ID beat and the closing beat.
  assign tail_hit   = item_valid && (err_hit || sum_hit);
  assign ptype_wide = (fb_nxt >> 4) & TYPE_MASK;

  always_comb begin
    cid_res             = '0;
    cid_res.kind        = cid_kind;
    cid_res.cid_byte    = item_byte;
    cid_res.cid_index   = 5'(fc_r);
    cid_res.end_of_item = !tail_hit;

    tail_res             = '0;
    tail_res.end_of_item = 1'b1;
    if (sum_hit) begin
      tail_res.kind              = K_DONE;
      tail_res.header_first_byte = fb_nxt;
      tail_res.packet_type       = ptype_wide[1:0];
      tail_res.version           = ver_nxt;
      tail_res.dest_id_len       = 5'(dl_nxt);
      tail_res.src_id_len        = 5'(sl_nxt);
      tail_res.header_len        = 6'(bc_nxt);
    end else begin
      tail_res.kind       = K_ERROR;
      tail_res.error_code = err_code;
    end
  end

  always_comb begin
    step.res0  = (item_valid && cid_hit) ? cid_res : tail_res;
    step.res1  = tail_res;
    step.count = {1'b0, item_valid && cid_hit} + {1'b0, tail_hit};
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      fc_r    <= '0;
      fb_r    <= '0;
      ver_r   <= '0;
      dl_r    <= '0;
      sl_r    <= '0;
      bc_r    <= '0;
    end else if (step_fire) begin
      phase_r <= phase_nxt;
      fc_r    <= fc_nxt;
      fb_r    <= fb_nxt;
      ver_r   <= ver_nxt;
      dl_r    <= dl_nxt;
      sl_r    <= sl_nxt;
      bc_r    <= bc_nxt;
    end
  end

endmodule

FILE: hw/rtl/quic_long_header_parser.sv
// Top level of the QUIC long header parser: input register, parser core, result queue.
// Path: a byte waits in the input register until its results have room in the result
// queue, where they are registered. Throughput: one byte per cycle while the queue has
// room; a byte's second beat waits in a slot behind the output register.
// Reset: synchronous, active low; empties both register stages and rearms the
// parser to wait for the first byte of a datagram.
`timescale 1ns / 1ps
`include "quic_long_header_parser_defines.svh"

module quic_long_header_parser
  import qlhp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // data_byte[7:0]
  input  logic                  in_tlast,   // last_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // cid_byte[7:0], cid_index[12:8], header_first_byte[20:13], packet_type[22:21],
  // version[54:23], dest_id_len[59:55], src_id_len[64:60], header_len[70:65],
  // error_code[72:71], zero fill[79:73]
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [OUT_USER_W-1:0] out_tuser,  // kind[1:0]
  output logic                  out_tlast   // end_of_item
);

  logic         ib_valid_r;
  logic [7:0]   ib_byte_r;
  logic         ib_last_r;

  logic         out_valid_r, out_valid_nxt;
  logic         sec_valid_r, sec_valid_nxt;
  qlhp_result_t out_res_r, out_res_nxt;
  qlhp_result_t sec_res_r, sec_res_nxt;

  qlhp_step_t   step;
  logic         pop;
  logic [1:0]   occ;
  logic [1:0]   remain;
  logic [1:0]   total;
  logic         step_fire;

  // Queue occupancy after this cycle's output beat leaves.
  assign pop    = out_valid_r && out_tready;
  assign occ    = {1'b0, out_valid_r} + {1'b0, sec_valid_r};
  assign remain = occ - {1'b0, pop};
  assign total  = remain + step.count;

  // A byte is parsed once its results are sure of a slot.
  assign step_fire = ib_valid_r && (({1'b0, remain} + {1'b0, step.count}) <= 3'd2);
  assign in_tready = !ib_valid_r || step_fire;

  qlhp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (ib_valid_r),
    .item_byte  (ib_byte_r),
    .item_last  (ib_last_r),
    .step_fire  (step_fire),
    .step       (step)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ib_valid_r <= 1'b0;
    end else if (in_tready) begin
      ib_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      ib_byte_r <= in_tdata;
      ib_last_r <= in_tlast;
    end
  end

  // Result queue: keep what is left, then append the new beats in order.
  always_comb begin
    if (remain != 2'd0) begin
      out_res_nxt = pop ? sec_res_r : out_res_r;
    end else begin
      out_res_nxt = step.res0;
    end
    if (remain == 2'd2) begin
      sec_res_nxt = sec_res_r;
    end else if (remain == 2'd1) begin
      sec_res_nxt = step.res0;
    end else begin
      sec_res_nxt = step.res1;
    end
    if (step_fire) begin
      out_valid_nxt = (total != 2'd0);
      sec_valid_nxt = (total == 2'd2);
    end else begin
      out_valid_nxt = (remain != 2'd0);
      sec_valid_nxt = (remain == 2'd2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sec_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sec_valid_r <= sec_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    sec_res_r <= sec_res_nxt;
  end

  // Output beat.
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tlast  = out_res_r.end_of_item;
  assign out_tdata  = {7'b0, out_res_r.error_code, out_res_r.header_len,
                       out_res_r.src_id_len, out_res_r.dest_id_len, out_res_r.version,
                       out_res_r.packet_type, out_res_r.header_first_byte,
                       out_res_r.cid_index, out_res_r.cid_byte};

  // The second slot is only ever filled behind the head.
  `QLHP_ASSERT_NOW(a_sec_behind_head, sec_valid_r, out_valid_r)
  // A byte with two beats leaves the queue full.
  `QLHP_ASSERT_NEXT(a_pair_fills_queue, step_fire && (step.count == 2'd2), sec_valid_r)
  // Summary and error beats always close their byte.
  `QLHP_ASSERT_NOW(a_tail_closes_item,
    out_valid_r && ((out_res_r.kind == K_DONE) || (out_res_r.kind == K_ERROR)),
    out_res_r.end_of_item)

endmodule

FILE: verif/quic_long_header_parser_tb.sv
// Self-checking testbench for the QUIC long header parser: byte stimulus, prediction, checks.
`timescale 1ns / 1ps

module quic_long_header_parser_tb
  import qlhp_pkg::*;
;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = 8'h00;   // data_byte[7:0]
  logic                  in_tlast = 1'b0;    // last_byte
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // cid_byte[7:0], cid_index[12:8], header_first_byte[20:13], packet_type[22:21],
  // version[54:23], dest_id_len[59:55], src_id_len[64:60], header_len[70:65],
  // error_code[72:71], zero fill[79:73]
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;          // kind[1:0]
  logic                  out_tlast;          // end_of_item

  quic_long_header_parser uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // Parser state as the predictor sees it, starting from its reset values.
  logic [2:0]   hdr_phase    = PH_FIRST;
  logic [7:0]   hdr_count    = 8'd0;
  logic [7:0]   hdr_first    = 8'd0;
  logic [31:0]  hdr_version  = 32'd0;
  logic [7:0]   hdr_dlen     = 8'd0;
  logic [7:0]   hdr_slen     = 8'd0;
  logic [15:0]  hdr_consumed = 16'd0;

  qlhp_result_t pending_results [$];
  logic [7:0]   frame [$];
  int           mismatches = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           hold_left = 0;

  function automatic qlhp_result_t error_result(input logic [1:0] code);
    qlhp_result_t r;
    r = '0;
    r.kind = K_ERROR;
    r.error_code = code;
    return r;
  endfunction

  function automatic qlhp_result_t cid_result(input logic [1:0] kind, input logic [7:0] b);
    qlhp_result_t r;
    r = '0;
    r.kind = kind;
    r.cid_byte = b;
    r.cid_index = hdr_count[4:0];
    return r;
  endfunction

  function automatic qlhp_result_t summary_result();
    qlhp_result_t r;
    r = '0;
    r.kind = K_DONE;
    r.header_first_byte = hdr_first;
    r.packet_type = hdr_first[5:4];
    r.version = hdr_version;
    r.dest_id_len = hdr_dlen[4:0];
    r.src_id_len = hdr_slen[4:0];
    r.header_len = hdr_consumed[5:0];
    return r;
  endfunction

  // Advance the header parse by one accepted byte and queue the beats it should cause.
  task automatic predict_header_byte(input logic [7:0] b, input logic is_last);
    qlhp_result_t res [2];
    int           n;
    logic         done;
    n = 0;
    done = 1'b0;
    if (hdr_phase != PH_SKIP && hdr_phase <= PH_SCID) hdr_consumed = hdr_consumed + 16'd1;
    case (hdr_phase)
      PH_FIRST: begin
        hdr_first = b;
        hdr_consumed = 16'd1;
        hdr_count = 8'd0;
        hdr_version = 32'd0;
        hdr_dlen = 8'd0;
        hdr_slen = 8'd0;
        if ((b & FORM_BIT) == 8'h00) begin
          res[n++] = error_result(E_FORM);
          done = 1'b1;
        end else if (is_last) begin
          res[n++] = error_result(E_TRUNC);
          done = 1'b1;
        end else begin
          hdr_phase = PH_VERSION;
        end
      end
      PH_VERSION: begin
        hdr_version = {hdr_version[23:0], b};
        hdr_count = hdr_count + 8'd1;
        if (is_last) begin
          res[n++] = error_result(E_TRUNC);
          done = 1'b1;
        end else if (hdr_count >= VERSION_BYTES) begin
          hdr_phase = PH_DLEN;
        end
      end
      PH_DLEN: begin
        hdr_dlen = b;
        if (b > MAX_ID_LEN) begin
          res[n++] = error_result(E_IDLEN);
          done = 1'b1;
        end else if (is_last) begin
          res[n++] = error_result(E_TRUNC);
          done = 1'b1;
        end else begin
          hdr_count = 8'd0;
          hdr_phase = (b == 8'd0) ? PH_SLEN : PH_DCID;
        end
      end
      PH_DCID: begin
        res[n++] = cid_result(K_DCID, b);
        hdr_count = hdr_count + 8'd1;
        if (is_last) begin
          res[n++] = error_result(E_TRUNC);
          done = 1'b1;
        end else if (hdr_count >= hdr_dlen) begin
          hdr_phase = PH_SLEN;
        end
      end
      PH_SLEN: begin
        hdr_slen = b;
        if (b > MAX_ID_LEN) begin
          res[n++] = error_result(E_IDLEN);
          done = 1'b1;
        end else if (b == 8'd0) begin
          res[n++] = summary_result();
          done = 1'b1;
        end else if (is_last) begin
          res[n++] = error_result(E_TRUNC);
          done = 1'b1;
        end else begin
          hdr_count = 8'd0;
          hdr_phase = PH_SCID;
        end
      end
      PH_SCID: begin
        res[n++] = cid_result(K_SCID, b);
        hdr_count = hdr_count + 8'd1;
        // A header that completes on the flagged byte still gives the summary.
        if (hdr_count >= hdr_slen) begin
          res[n++] = summary_result();
          done = 1'b1;
        end else if (is_last) begin
          res[n++] = error_result(E_TRUNC);
          done = 1'b1;
        end
      end
      default: ;
    endcase
    if (is_last) hdr_phase = PH_FIRST;
    else if (done) hdr_phase = PH_SKIP;
    if (n > 0) res[n-1].end_of_item = 1'b1;
    for (int i = 0; i < n; i++) pending_results.push_back(res[i]);
  endtask

  // Offer one byte, with random idle cycles in front, and predict once it is taken.
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= is_last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_header_byte(b, is_last);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame.size(); i++) send_byte(frame[i], i == frame.size() - 1);
  endtask

  function automatic int pick_cid_len();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 0;
    if (r == 1) return MAX_ID_LEN;
    return $urandom_range(6, 1);
  endfunction

  // Fill the frame with one random datagram; returns the bytes that reach the parser.
  function automatic int build_random_datagram();
    int          pick;
    int          dlen;
    int          slen;
    int          header_bytes;
    int          r;
    logic [31:0] ver;
    frame.delete();
    pick = $urandom_range(99);
    if (pick >= 88) begin
      // Pure noise, whatever the first byte happens to say.
      header_bytes = $urandom_range(6, 1);
      for (int i = 0; i < header_bytes; i++) frame.push_back(8'($urandom_range(255)));
      return header_bytes;
    end
    if (pick >= 80) begin
      frame.push_back(8'($urandom_range(127)));
    end else begin
      frame.push_back(FORM_BIT | 8'($urandom_range(127)));
      r = $urandom_range(9);
      ver = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom();
      for (int i = VERSION_BYTES - 1; i >= 0; i--) frame.push_back(ver[8*i +: 8]);
      dlen = pick_cid_len();
      slen = pick_cid_len();
      // Some headers carry a length past the limit.
      if (pick >= 70) begin
        if ($urandom_range(1) == 1) dlen = $urandom_range(255, MAX_ID_LEN + 1);
        else slen = $urandom_range(255, MAX_ID_LEN + 1);
      end
      frame.push_back(8'(dlen));
      if (dlen <= MAX_ID_LEN) begin
        for (int i = 0; i < dlen; i++) frame.push_back(8'($urandom_range(255)));
        frame.push_back(8'(slen));
        if (slen <= MAX_ID_LEN)
          for (int i = 0; i < slen; i++) frame.push_back(8'($urandom_range(255)));
      end
    end
    header_bytes = frame.size();
    // Cut a quarter of the well-formed headers short; otherwise add trailing bytes.
    if (pick < 70 && $urandom_range(3) == 0) begin
      header_bytes = $urandom_range(frame.size() - 1, 1);
      while (frame.size() > header_bytes) void'(frame.pop_back());
    end else begin
      r = $urandom_range(3);
      for (int i = 0; i < r; i++) frame.push_back(8'($urandom_range(255)));
    end
    return frame.size();
  endfunction

  task automatic test_first_byte_errors();
    send_byte(8'h00, 1'b1);   // form bit clear
    send_byte(8'hC0, 1'b1);   // datagram ends on the first byte
    send_byte(8'hFF, 1'b0);   // ends inside the version
    send_byte(8'h12, 1'b1);
  endtask

  task automatic test_length_limit();
    // DCID length over the limit on the flagged byte.
    send_byte(8'h80, 1'b0);
    for (int i = 1; i <= VERSION_BYTES; i++) send_byte(8'(i), 1'b0);
    send_byte(8'(MAX_ID_LEN + 1), 1'b1);
  endtask

  task automatic test_cid_sequences();
    // A DCID byte that is also the last byte: the byte, then a truncation error.
    send_byte(8'hE0, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    send_byte(8'h78, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hAB, 1'b1);
    // The final SCID byte ends the datagram: the byte, then the summary.
    send_byte(8'hF5, 1'b0);
    for (int i = 0; i < VERSION_BYTES; i++) send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h5A, 1'b1);
  endtask

  // Hold the result side off for a long stretch while bytes keep coming.
  task automatic test_backpressure();
    int sent;
    sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(negedge clk);
    in_tvalid <= 1'b0;
    hold_left = 150;
    while (sent < 60) begin
      sent += build_random_datagram();
      send_frame();
    end
  endtask

  task automatic test_random_traffic(input int total_bytes);
    int idle_by_phase [4];
    int stall_by_phase [4];
    int sent;
    idle_by_phase = '{0, 60, 0, 32};
    stall_by_phase = '{0, 0, 60, 32};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_by_phase[p];
      recv_stall_pct = stall_by_phase[p];
      sent = 0;
      while (sent < total_bytes / 4) begin
        sent += build_random_datagram();
        send_frame();
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // Result side: random stalls, or a counted hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic void check_field(input string name, input logic [31:0] exp_val,
                                      input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      mismatches++;
    end
  endfunction

  // Compare every result beat with the oldest prediction.
  always @(posedge clk) begin : result_check
    qlhp_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no prediction waiting: kind 0x%0h", out_tuser);
        mismatches++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("kind", 32'(exp_r.kind), 32'(out_tuser));
        check_field("cid_byte", 32'(exp_r.cid_byte), 32'(out_tdata[7:0]));
        check_field("cid_index", 32'(exp_r.cid_index), 32'(out_tdata[12:8]));
        check_field("header_first_byte", 32'(exp_r.header_first_byte),
                    32'(out_tdata[20:13]));
        check_field("packet_type", 32'(exp_r.packet_type), 32'(out_tdata[22:21]));
        check_field("version", exp_r.version, out_tdata[54:23]);
        check_field("dest_id_len", 32'(exp_r.dest_id_len), 32'(out_tdata[59:55]));
        check_field("src_id_len", 32'(exp_r.src_id_len), 32'(out_tdata[64:60]));
        check_field("header_len", 32'(exp_r.header_len), 32'(out_tdata[70:65]));
        check_field("error_code", 32'(exp_r.error_code), 32'(out_tdata[72:71]));
        check_field("zero_fill", 32'd0, 32'(out_tdata[79:73]));
        check_field("end_of_item", 32'(exp_r.end_of_item), 32'(out_tlast));
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_first_byte_errors();
    test_length_limit();
    test_cid_sequences();
    test_backpressure();
    test_random_traffic(300);

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d predicted results never arrived", pending_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("PASS quic_long_header_parser");
    end else begin
      $display("FAIL quic_long_header_parser");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("FAIL quic_long_header_parser");
    $finish;
  end

endmodule
